// ----- rtl/uvls_pkg.sv -----
package uvls_pkg;

	localparam int unsigned REG_BITS   = 24;
	localparam int unsigned COUNT_BITS = 24;
	localparam int unsigned CFG_IDX_BITS = 2;
	localparam logic [REG_BITS-1:0] TICKS_RESET = REG_BITS'(1000);

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_ARM_TICKS  = 2'd0,
		REG_SAFE_TICKS = 2'd1,
		REG_RUN_TICKS  = 2'd2
	} reg_idx_t;

	typedef enum logic [3:0] {
		PH_IDLE       = 4'd0,
		PH_START_ARM  = 4'd1,
		PH_ARMING     = 4'd2,
		PH_START_SAFE = 4'd3,
		PH_SAFE_WAIT  = 4'd4,
		PH_LAMP_ON    = 4'd5,
		PH_START_RUN  = 4'd6,
		PH_RUNNING    = 4'd7,
		PH_ABORT      = 4'd8,
		PH_TURN_OFF   = 4'd9
	} phase_t;

	typedef enum logic [1:0] {
		CMD_NONE = 2'd0,
		CMD_ON   = 2'd1,
		CMD_OFF  = 2'd2
	} lamp_cmd_t;

	typedef enum logic [1:0] {
		LED_OFF   = 2'd0,
		LED_BLINK = 2'd1,
		LED_SOLID = 2'd2
	} led_mode_t;

	typedef struct packed {
		phase_t    phase;
		logic      motion_pending;
		logic      armed;
		led_mode_t led;
	} ctl_t;

	typedef struct packed {
		logic motion_event;
		logic button_event;
		logic abort_request;
		logic white_on;
	} tick_t;

	typedef struct packed {
		logic [REG_BITS-1:0] arm_ticks;
		logic [REG_BITS-1:0] safe_ticks;
		logic [REG_BITS-1:0] run_ticks;
	} cfg_t;

endpackage

// ----- rtl/uvls_cfg_regs.sv -----
module uvls_cfg_regs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              wr_en,
	input  logic [uvls_pkg::CFG_IDX_BITS-1:0] wr_index,
	input  logic [uvls_pkg::REG_BITS-1:0]     wr_data,
	output uvls_pkg::cfg_t                    cfg
);

	uvls_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.arm_ticks  <= uvls_pkg::TICKS_RESET;
			cfg_q.safe_ticks <= uvls_pkg::TICKS_RESET;
			cfg_q.run_ticks  <= uvls_pkg::TICKS_RESET;
		end else if (wr_en) begin
			case (wr_index)
				uvls_pkg::REG_ARM_TICKS:  cfg_q.arm_ticks  <= wr_data;
				uvls_pkg::REG_SAFE_TICKS: cfg_q.safe_ticks <= wr_data;
				uvls_pkg::REG_RUN_TICKS:  cfg_q.run_ticks  <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- rtl/uvls_step.sv -----
module uvls_step #(
	parameter int unsigned COUNT_BITS = uvls_pkg::COUNT_BITS
) (
	input  uvls_pkg::tick_t        tick,
	input  uvls_pkg::cfg_t         cfg,
	input  uvls_pkg::ctl_t         ctl,
	input  logic [COUNT_BITS-1:0]  arm_count,
	input  logic [COUNT_BITS-1:0]  safe_count,
	input  logic [COUNT_BITS-1:0]  run_count,
	output uvls_pkg::ctl_t         ctl_nxt,
	output logic [COUNT_BITS-1:0]  arm_count_nxt,
	output logic [COUNT_BITS-1:0]  safe_count_nxt,
	output logic [COUNT_BITS-1:0]  run_count_nxt,
	output uvls_pkg::lamp_cmd_t    cmd
);

	localparam int unsigned LW = (COUNT_BITS > uvls_pkg::REG_BITS) ?
		COUNT_BITS : uvls_pkg::REG_BITS;
	localparam logic [LW-1:0] CMAX = LW'({COUNT_BITS{1'b1}});

	function automatic logic [COUNT_BITS-1:0] load_count(
		input logic [uvls_pkg::REG_BITS-1:0] ticks);
		logic [LW-1:0] ext;
		ext = LW'(ticks);
		if (ext > CMAX)
			ext = CMAX;
		return ext[COUNT_BITS-1:0];
	endfunction

	function automatic logic [COUNT_BITS-1:0] tick_down(input logic [COUNT_BITS-1:0] c);
		return (c != '0) ? c - COUNT_BITS'(1) : '0;
	endfunction

	uvls_pkg::phase_t ph;

	always_comb begin
		ctl_nxt = ctl;
		cmd = uvls_pkg::CMD_NONE;
		ctl_nxt.motion_pending = ctl.motion_pending | tick.motion_event;
		ctl_nxt.armed = ctl.armed ^ tick.button_event;
		arm_count_nxt  = tick_down(arm_count);
		safe_count_nxt = tick_down(safe_count);
		run_count_nxt  = tick_down(run_count);

		ph = ctl.phase;
		if (tick.button_event)
			ph = ctl_nxt.armed ? uvls_pkg::PH_START_ARM : uvls_pkg::PH_ABORT;
		if (tick.abort_request)
			ph = uvls_pkg::PH_ABORT;
		ctl_nxt.phase = ph;

		case (ph)
			uvls_pkg::PH_IDLE: begin
				ctl_nxt.motion_pending = 1'b0;
			end
			uvls_pkg::PH_START_ARM: begin
				arm_count_nxt = load_count(cfg.arm_ticks);
				ctl_nxt.led = uvls_pkg::LED_BLINK;
				ctl_nxt.phase = uvls_pkg::PH_ARMING;
			end
			uvls_pkg::PH_ARMING: begin
				ctl_nxt.motion_pending = 1'b0;
				if (arm_count_nxt == '0) begin
					ctl_nxt.phase = uvls_pkg::PH_START_SAFE;
					ctl_nxt.led = uvls_pkg::LED_SOLID;
				end
			end
			uvls_pkg::PH_START_SAFE: begin
				safe_count_nxt = load_count(cfg.safe_ticks);
				ctl_nxt.phase = uvls_pkg::PH_SAFE_WAIT;
			end
			uvls_pkg::PH_SAFE_WAIT: begin
				if (safe_count_nxt == '0) begin
					ctl_nxt.phase = uvls_pkg::PH_LAMP_ON;
				end else if (ctl_nxt.motion_pending) begin
					ctl_nxt.motion_pending = 1'b0;
					ctl_nxt.phase = uvls_pkg::PH_ABORT;
				end else if (tick.white_on) begin
					ctl_nxt.phase = uvls_pkg::PH_START_SAFE;
				end
			end
			uvls_pkg::PH_LAMP_ON: begin
				cmd = uvls_pkg::CMD_ON;
				ctl_nxt.phase = uvls_pkg::PH_START_RUN;
			end
			uvls_pkg::PH_START_RUN: begin
				run_count_nxt = load_count(cfg.run_ticks);
				ctl_nxt.phase = uvls_pkg::PH_RUNNING;
			end
			uvls_pkg::PH_RUNNING: begin
				if (run_count_nxt == '0)
					ctl_nxt.phase = uvls_pkg::PH_TURN_OFF;
				if (ctl_nxt.motion_pending) begin
					ctl_nxt.motion_pending = 1'b0;
					ctl_nxt.phase = uvls_pkg::PH_ABORT;
				end
			end
			uvls_pkg::PH_ABORT: begin
				ctl_nxt.phase = uvls_pkg::PH_TURN_OFF;
			end
			uvls_pkg::PH_TURN_OFF: begin
				arm_count_nxt  = '0;
				safe_count_nxt = '0;
				run_count_nxt  = '0;
				ctl_nxt.armed = 1'b0;
				cmd = uvls_pkg::CMD_OFF;
				ctl_nxt.led = uvls_pkg::LED_OFF;
				ctl_nxt.phase = uvls_pkg::PH_IDLE;
			end
			default: begin
				ctl_nxt.phase = uvls_pkg::PH_IDLE;
			end
		endcase
	end

endmodule

// ----- rtl/uv_lamp_safety_sequencer.sv -----
// UV lamp safety sequencer. One tick beat in, one status beat out, one beat per
// clock sustained while the output is not stalled: a tick is held in an input
// register, the phase update and the three deadline down-counters are evaluated
// combinationally from there, and the status lands in an output register. Input
// ready drops only while both the input register and the output register are
// full and the output is stalled. Configuration writes are always ready and
// should only be made while no tick is in flight.
module uv_lamp_safety_sequencer #(
	parameter int unsigned COUNT_BITS = uvls_pkg::COUNT_BITS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [7:0]                        s_tdata,   // motion_event, button_event, abort_request, white_on
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [15:0]                       m_tdata,   // lamp_command[1:0], led_mode[1:0], armed, phase[3:0]
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [uvls_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [uvls_pkg::REG_BITS-1:0]     cfg_data
);

	uvls_pkg::cfg_t      cfg;
	uvls_pkg::tick_t     tick_s1;
	logic                valid_s1;
	uvls_pkg::ctl_t      ctl_q, ctl_nxt;
	logic [COUNT_BITS-1:0] arm_count_q, safe_count_q, run_count_q;
	logic [COUNT_BITS-1:0] arm_count_nxt, safe_count_nxt, run_count_nxt;
	uvls_pkg::lamp_cmd_t cmd;
	logic                out_valid_q;
	logic [15:0]         out_data_q;
	logic                out_free, advance;

	assign cfg_ready = 1'b1;

	uvls_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	assign out_free = !out_valid_q || m_tready;
	assign advance  = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			tick_s1.motion_event  <= s_tdata[0];
			tick_s1.button_event  <= s_tdata[1];
			tick_s1.abort_request <= s_tdata[2];
			tick_s1.white_on      <= s_tdata[3];
		end
	end

	uvls_step #(
		.COUNT_BITS (COUNT_BITS)
	) u_step (
		.tick           (tick_s1),
		.cfg            (cfg),
		.ctl            (ctl_q),
		.arm_count      (arm_count_q),
		.safe_count     (safe_count_q),
		.run_count      (run_count_q),
		.ctl_nxt        (ctl_nxt),
		.arm_count_nxt  (arm_count_nxt),
		.safe_count_nxt (safe_count_nxt),
		.run_count_nxt  (run_count_nxt),
		.cmd            (cmd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q.phase          <= uvls_pkg::PH_IDLE;
			ctl_q.motion_pending <= 1'b0;
			ctl_q.armed          <= 1'b0;
			ctl_q.led            <= uvls_pkg::LED_OFF;
			arm_count_q  <= '0;
			safe_count_q <= '0;
			run_count_q  <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (advance) begin
				ctl_q        <= ctl_nxt;
				arm_count_q  <= arm_count_nxt;
				safe_count_q <= safe_count_nxt;
				run_count_q  <= run_count_nxt;
			end
			if (out_free)
				out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			out_data_q <= {7'd0, ctl_nxt.phase, ctl_nxt.armed, ctl_nxt.led, cmd};
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	a_on_then_start_run: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[1:0] == uvls_pkg::CMD_ON) |->
		(m_tdata[8:5] == uvls_pkg::PH_START_RUN))
		else $error("lamp on without entering run start");

	a_off_clears: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[1:0] == uvls_pkg::CMD_OFF) |->
		(ctl_q.phase == uvls_pkg::PH_IDLE) && !ctl_q.armed && (arm_count_q == '0) &&
		(safe_count_q == '0) && (run_count_q == '0) && (ctl_q.led == uvls_pkg::LED_OFF))
		else $error("turn-off left state behind");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> valid_s1 && m_tvalid && !m_tready)
		else $error("input stalled with room available");

	a_state_held_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(ctl_q) && $stable(run_count_q))
		else $error("sequencer state moved without a beat");

endmodule

// ----- sim/uv_lamp_safety_sequencer_tb.sv -----
`timescale 1ns / 1ps

module uv_lamp_safety_sequencer_tb;
	import uvls_pkg::*;

	localparam int CLK_HALF    = 4;
	localparam int SETTLE      = 4;
	localparam int TAIL        = 8;
	localparam int STALL_LIMIT = 2000;
	localparam int PHASE_ITEMS = 150;
	localparam int PHASES      = 8;
	localparam int DIR_ROWS    = 29;
	localparam longint unsigned COUNT_MAX = (64'd1 << COUNT_BITS) - 1;
	localparam logic [REG_BITS-1:0] TICKS_MAX = '1;

	typedef struct packed {
		lamp_cmd_t cmd;
		led_mode_t led;
		logic      armed;
		phase_t    phase;
	} status_t;

	typedef struct packed {
		logic                is_cfg;
		reg_idx_t            idx;
		logic [REG_BITS-1:0] data;
		logic [3:0]          tick;   // white, abort, button, motion
		logic                known;
		status_t             res;
	} dir_row_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    s_tvalid = 1'b0;
	logic                    s_tready;
	logic [7:0]              s_tdata = '0;
	logic                    m_tvalid;
	logic                    m_tready = 1'b0;
	logic [15:0]             m_tdata;
	logic                    cfg_valid = 1'b0;
	logic                    cfg_ready;
	logic [CFG_IDX_BITS-1:0] cfg_index = '0;
	logic [REG_BITS-1:0]     cfg_data = '0;

	uv_lamp_safety_sequencer uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #CLK_HALF clk = ~clk;

	// sequencer shadow
	logic [REG_BITS-1:0]   arm_len = TICKS_RESET;
	logic [REG_BITS-1:0]   safe_len = TICKS_RESET;
	logic [REG_BITS-1:0]   run_len = TICKS_RESET;
	phase_t                seq_ph = PH_IDLE;
	logic                  motion_seen = 1'b0;
	logic                  armed_q = 1'b0;
	logic [COUNT_BITS-1:0] arm_left = '0;
	logic [COUNT_BITS-1:0] safe_left = '0;
	logic [COUNT_BITS-1:0] run_left = '0;
	led_mode_t             led_q = LED_OFF;

	status_t status_q[$];
	int      send_idle_pct = 0;
	int      recv_stall_pct = 0;
	int      err_cnt = 0;
	int      tick_cnt = 0;
	int      cfg_cnt = 0;
	int      on_cnt = 0;
	int      off_cnt = 0;
	int      quiet = 0;

	function automatic logic [COUNT_BITS-1:0] clamp_load(logic [REG_BITS-1:0] v);
		if (64'(v) > COUNT_MAX)
			return COUNT_BITS'(COUNT_MAX);
		return COUNT_BITS'(v);
	endfunction

	function automatic status_t next_status(logic [3:0] t);
		status_t   s;
		lamp_cmd_t cmd;
		cmd = CMD_NONE;
		if (t[0])
			motion_seen = 1'b1;
		if (t[1])
			armed_q = ~armed_q;
		if (arm_left != 0)
			arm_left = arm_left - 1'b1;
		if (safe_left != 0)
			safe_left = safe_left - 1'b1;
		if (run_left != 0)
			run_left = run_left - 1'b1;
		if (t[1])
			seq_ph = armed_q ? PH_START_ARM : PH_ABORT;
		if (t[2])
			seq_ph = PH_ABORT;
		case (seq_ph)
			PH_IDLE: begin
				motion_seen = 1'b0;
			end
			PH_START_ARM: begin
				arm_left = clamp_load(arm_len);
				led_q = LED_BLINK;
				seq_ph = PH_ARMING;
			end
			PH_ARMING: begin
				motion_seen = 1'b0;
				if (arm_left == 0) begin
					seq_ph = PH_START_SAFE;
					led_q = LED_SOLID;
				end
			end
			PH_START_SAFE: begin
				safe_left = clamp_load(safe_len);
				seq_ph = PH_SAFE_WAIT;
			end
			PH_SAFE_WAIT: begin
				if (safe_left == 0) begin
					seq_ph = PH_LAMP_ON;
				end else if (motion_seen) begin
					motion_seen = 1'b0;
					seq_ph = PH_ABORT;
				end else if (t[3]) begin
					seq_ph = PH_START_SAFE;
				end
			end
			PH_LAMP_ON: begin
				cmd = CMD_ON;
				seq_ph = PH_START_RUN;
			end
			PH_START_RUN: begin
				run_left = clamp_load(run_len);
				seq_ph = PH_RUNNING;
			end
			PH_RUNNING: begin
				if (run_left == 0)
					seq_ph = PH_TURN_OFF;
				if (motion_seen) begin
					motion_seen = 1'b0;
					seq_ph = PH_ABORT;
				end
			end
			PH_ABORT: begin
				seq_ph = PH_TURN_OFF;
			end
			PH_TURN_OFF: begin
				arm_left = '0;
				safe_left = '0;
				run_left = '0;
				armed_q = 1'b0;
				cmd = CMD_OFF;
				led_q = LED_OFF;
				seq_ph = PH_IDLE;
			end
			default: begin
				seq_ph = PH_IDLE;
			end
		endcase
		s.cmd = cmd;
		s.led = led_q;
		s.armed = armed_q;
		s.phase = seq_ph;
		return s;
	endfunction

	function automatic dir_row_t tick_row(logic m, logic b, logic a, logic w);
		dir_row_t r;
		r = '0;
		r.tick = {w, a, b, m};
		return r;
	endfunction

	function automatic dir_row_t known_row(logic m, logic b, logic a, logic w,
			lamp_cmd_t c, led_mode_t l, logic ar, phase_t p);
		dir_row_t r;
		r = tick_row(m, b, a, w);
		r.known = 1'b1;
		r.res.cmd = c;
		r.res.led = l;
		r.res.armed = ar;
		r.res.phase = p;
		return r;
	endfunction

	function automatic dir_row_t reg_row(reg_idx_t idx, logic [REG_BITS-1:0] v);
		dir_row_t r;
		r = '0;
		r.is_cfg = 1'b1;
		r.idx = idx;
		r.data = v;
		return r;
	endfunction

	function automatic dir_row_t directed_row(int i);
		case (i)
			0:  return known_row(0, 0, 0, 0, CMD_NONE, LED_OFF, 1'b0, PH_IDLE);
			1:  return known_row(0, 0, 1, 0, CMD_NONE, LED_OFF, 1'b0, PH_TURN_OFF);
			2:  return known_row(0, 0, 0, 0, CMD_OFF, LED_OFF, 1'b0, PH_IDLE);
			3:  return known_row(0, 1, 0, 0, CMD_NONE, LED_BLINK, 1'b1, PH_ARMING);
			4:  return tick_row(1, 0, 0, 0);   // motion while arming is dropped
			5:  return tick_row(0, 1, 0, 0);   // disarm
			6:  return tick_row(0, 0, 0, 0);
			7:  return reg_row(REG_ARM_TICKS, 24'd1);
			8:  return reg_row(REG_SAFE_TICKS, 24'd2);
			9:  return reg_row(REG_RUN_TICKS, 24'd0);
			10: return tick_row(0, 1, 0, 0);
			11: return tick_row(1, 0, 0, 1);
			12: return tick_row(0, 0, 0, 1);
			13: return tick_row(0, 0, 0, 1);   // white restarts the safe wait
			14: return tick_row(0, 0, 0, 0);
			15: return tick_row(0, 0, 0, 0);
			16: return tick_row(0, 0, 0, 0);
			17: return tick_row(1, 0, 0, 0);   // motion held through lamp-on
			18: return tick_row(0, 0, 0, 0);
			19: return tick_row(0, 0, 0, 0);   // zero run time vs pending motion
			20: return tick_row(1, 0, 0, 0);
			21: return tick_row(0, 0, 0, 0);
			22: return tick_row(0, 0, 0, 0);
			23: return tick_row(0, 1, 1, 0);   // button and abort together
			24: return tick_row(0, 0, 0, 0);
			25: return reg_row(REG_ARM_TICKS, TICKS_MAX);
			26: return tick_row(0, 1, 0, 0);
			27: return tick_row(1, 1, 1, 1);
			default: return tick_row(0, 0, 0, 0);
		endcase
	endfunction

	function automatic logic [3:0] gen_tick();
		logic m, b, a, w;
		if ($urandom_range(9) == 0)
			return 4'($urandom);
		m = ($urandom_range(19) == 0);
		a = ($urandom_range(59) == 0);
		w = ($urandom_range(9) == 0);
		b = (seq_ph == PH_IDLE) ? ($urandom_range(2) == 0) : ($urandom_range(49) == 0);
		return {w, a, b, m};
	endfunction

	function automatic logic [REG_BITS-1:0] pick_len();
		if ($urandom_range(7) == 0)
			return REG_BITS'($urandom_range(300, 16));
		return REG_BITS'($urandom_range(8));
	endfunction

	task automatic tick_beat(logic [3:0] t, logic known, status_t res);
		status_t p;
		int      gap;
		s_tdata <= {4'b0000, t};
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		p = next_status(t);
		status_q.push_back(known ? res : p);
		tick_cnt++;
		if (p.cmd == CMD_ON)
			on_cnt++;
		if (p.cmd == CMD_OFF)
			off_cnt++;
		gap = 0;
		while ($urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic write_reg(reg_idx_t idx, logic [REG_BITS-1:0] v);
		s_tvalid <= 1'b0;
		while (status_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		cfg_index <= idx;
		cfg_data <= v;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		cfg_cnt++;
		case (idx)
			REG_ARM_TICKS:  arm_len = v;
			REG_SAFE_TICKS: safe_len = v;
			REG_RUN_TICKS:  run_len = v;
			default: ;
		endcase
	endtask

	task automatic check_status(logic [15:0] d);
		status_t e;
		if (status_q.size() == 0) begin
			err_cnt++;
			if (err_cnt <= 10)
				$display("Unexpected status beat %h", d);
		end else begin
			e = status_q.pop_front();
			if (d[1:0] !== e.cmd || d[3:2] !== e.led || d[4] !== e.armed
					|| d[8:5] !== e.phase) begin
				err_cnt++;
				if (err_cnt <= 10)
					$display("Status mismatch: exp cmd %0d led %0d armed %0d phase %0d, got cmd %0d led %0d armed %0d phase %0d",
						e.cmd, e.led, e.armed, e.phase, d[1:0], d[3:2], d[4], d[8:5]);
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			check_status(m_tdata);
		if (!arst_n)
			m_tready <= 1'b0;
		else
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
				|| (cfg_valid && cfg_ready)) begin
			quiet <= 0;
		end else begin
			quiet <= quiet + 1;
			if (quiet >= STALL_LIMIT) begin
				$display("Watchdog: no beat for %0d cycles, %0d results outstanding",
					quiet, status_q.size());
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	initial begin
		dir_row_t r;
		status_t  none;
		none = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIR_ROWS; i++) begin
			r = directed_row(i);
			if (r.is_cfg)
				write_reg(r.idx, r.data);
			else
				tick_beat(r.tick, r.known, r.res);
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
				default: begin send_idle_pct = 35; recv_stall_pct = 35; end
			endcase
			case (ph)
				5: begin
					write_reg(REG_ARM_TICKS, '0);
					write_reg(REG_SAFE_TICKS, 24'd1);
					write_reg(REG_RUN_TICKS, TICKS_MAX);
				end
				6: begin
					write_reg(REG_ARM_TICKS, 24'd1);
					write_reg(REG_SAFE_TICKS, '0);
					write_reg(REG_RUN_TICKS, '0);
				end
				default: begin
					write_reg(REG_ARM_TICKS, pick_len());
					write_reg(REG_SAFE_TICKS, pick_len());
					write_reg(REG_RUN_TICKS, pick_len());
				end
			endcase
			for (int n = 0; n < PHASE_ITEMS; n++)
				tick_beat(gen_tick(), 1'b0, none);
		end

		s_tvalid <= 1'b0;
		while (status_q.size() != 0)
			@(posedge clk);
		repeat (TAIL) @(posedge clk);

		$display("Ran %0d ticks across %0d register writes and four idle/stall mixes,",
			tick_cnt, cfg_cnt);
		$display("with %0d lamp-on and %0d lamp-off commands; %0d mismatches, %0d left over.",
			on_cnt, off_cnt, err_cnt, status_q.size());
		if (err_cnt == 0 && status_q.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/uvls_pkg.sv
rtl/uvls_cfg_regs.sv
rtl/uvls_step.sv
rtl/uv_lamp_safety_sequencer.sv
sim/uv_lamp_safety_sequencer_tb.sv
